/* design/rectangle_canvas_rasterizer_defines.svh */
// assertion macros for the rectangle canvas rasterizer
// expects signals named clk and rst_n in the scope of use
`ifndef RECTANGLE_CANVAS_RASTERIZER_DEFINES_SVH
`define RECTANGLE_CANVAS_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define RCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCR_ASSERT_IMP(lbl, ante, cons, msg)
`define RCR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* design/rcr_pkg.sv */
// shared types and constants for the rectangle canvas rasterizer
// no dependencies
`timescale 1ns / 1ps

package rcr_pkg;

  // port widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // item kinds, carried in tuser
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE  = 2'd1;
  localparam logic [1:0] STAT_BAD_SHAPE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [7:0] BG_RESET     = 8'd32;
  localparam logic [7:0] CHAR_FILL    = 8'h52;  // 'R'
  localparam logic [7:0] CHAR_OUTLINE = 8'h72;  // 'r'

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch the input transaction
    logic setup;     // derive box bounds, reset scan counters
    logic scan;      // visit one canvas cell
    logic mem_rd;    // read one canvas cell
    logic out_load;  // load the result register
  } rcr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic       scan_last;
  } rcr_stat_t;

endpackage

/* design/rcr_ctrl.sv */
// controller state machine of the rectangle canvas rasterizer
// depends on rcr_pkg; drives commands to rcr_datapath
`timescale 1ns / 1ps

module rcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  rcr_pkg::rcr_stat_t stat,
  output rcr_pkg::rcr_cmd_t  cmd
);
  import rcr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_CLEAR = 6'b000100,
    S_DRAW  = 6'b001000,
    S_RADDR = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        case (stat.kind)
          KIND_CLEAR: state_nxt = S_CLEAR;
          KIND_DRAW:  state_nxt = (stat.status == STAT_OK) ? S_DRAW : S_DONE;
          KIND_READ:  state_nxt = S_RADDR;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_CLEAR, S_DRAW: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RADDR: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to drain
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* design/rcr_datapath.sv */
// datapath of the rectangle canvas rasterizer: config registers, field latch,
// box bounds, cell scan counters, canvas ram and result register; uses rcr_pkg
`timescale 1ns / 1ps

module rcr_datapath #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [rcr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                       in_tuser,
  input  rcr_pkg::rcr_cmd_t                cmd,
  output rcr_pkg::rcr_stat_t               stat,
  output logic [rcr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import rcr_pkg::*;

  localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = ((IDX_W + FRAC_BITS + 1) > 25) ? (IDX_W + FRAC_BITS + 1) : 25;
  localparam int DW     = CW + 2;
  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;
  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'((MAX_SIDE < 256) ? MAX_SIDE : 256);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    logic [SIDE_W-1:0] res;
    if (v == '0) begin
      res = SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = SIDE_W'(v);
    end
    return res;
  endfunction

  // configuration
  logic [SIDE_W-1:0] width_r, height_r;
  logic [7:0]        bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RST;
      height_r <= SIDE_RST;
      bg_r     <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  width_r  <= clamp_side(cfg_wdata);
        CFG_CANVAS_HEIGHT: height_r <= clamp_side(cfg_wdata);
        CFG_BACKGROUND:    bg_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // latched input fields
  logic [1:0]         kind_r;
  logic [7:0]         shape_r, draw_r, row_r, col_r;
  logic signed [23:0] left_r, top_r, rw_r, rh_r;

  // derived bounds and scan state
  logic signed [DW-1:0] x0_r, x1_r, y0_r, y1_r, x0p_r, x1m_r, y0p_r, y1m_r;
  logic                 outline_r, inrange_r;
  logic [IDX_W-1:0]     row_cnt_r, col_cnt_r;
  logic [AW-1:0]        addr_r, base_r;
  logic [7:0]           rd_data_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [1:0]           draw_status;
  logic [AW-1:0]        rd_addr;
  logic signed [DW-1:0] px, py;
  logic                 col_last, row_last, covered, edge_hit, mem_we;
  logic [7:0]           wdata, pix;
  logic [1:0]           res_status;

  logic [7:0] mem [DEPTH];

  always_comb begin
    if (rw_r[23] || rw_r == '0 || rh_r[23] || rh_r == '0) begin
      draw_status = STAT_BAD_SIZE;
    end else if (shape_r != CHAR_FILL && shape_r != CHAR_OUTLINE) begin
      draw_status = STAT_BAD_SHAPE;
    end else begin
      draw_status = STAT_OK;
    end
  end

  assign rd_addr = AW'(32'(row_r) * 32'(MAX_SIDE) + 32'(col_r));

  assign px = DW'(col_cnt_r) << FRAC_BITS;
  assign py = DW'(row_cnt_r) << FRAC_BITS;

  assign col_last = (SIDE_W'(col_cnt_r) == width_r - SIDE_W'(1));
  assign row_last = (SIDE_W'(row_cnt_r) == height_r - SIDE_W'(1));

  // closed box, and the band within one unit of any edge
  assign covered  = (py >= y0_r) && (py <= y1_r) && (px >= x0_r) && (px <= x1_r);
  assign edge_hit = (py > y1m_r) || (py < y0p_r) || (px > x1m_r) || (px < x0p_r);

  assign mem_we = cmd.scan &&
                  ((kind_r == KIND_CLEAR) || (covered && (!outline_r || edge_hit)));
  assign wdata  = (kind_r == KIND_CLEAR) ? bg_r : draw_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_tuser;
      shape_r <= in_tdata[7:0];
      left_r  <= in_tdata[31:8];
      top_r   <= in_tdata[55:32];
      rw_r    <= in_tdata[79:56];
      rh_r    <= in_tdata[103:80];
      draw_r  <= in_tdata[111:104];
      row_r   <= in_tdata[119:112];
      col_r   <= in_tdata[127:120];
    end

    if (cmd.setup) begin
      x0_r      <= DW'(left_r);
      y0_r      <= DW'(top_r);
      x1_r      <= DW'(left_r) + DW'(rw_r);
      y1_r      <= DW'(top_r) + DW'(rh_r);
      x0p_r     <= DW'(left_r) + ONE;
      y0p_r     <= DW'(top_r) + ONE;
      x1m_r     <= DW'(left_r) + DW'(rw_r) - ONE;
      y1m_r     <= DW'(top_r) + DW'(rh_r) - ONE;
      outline_r <= (shape_r == CHAR_OUTLINE);
      inrange_r <= (32'(row_r) < 32'(height_r)) && (32'(col_r) < 32'(width_r));
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      base_r    <= '0;
      addr_r    <= (kind_r == KIND_READ) ? rd_addr : '0;
    end else if (cmd.scan) begin
      if (col_last) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_cnt_r + IDX_W'(1);
        base_r    <= base_r + AW'(MAX_SIDE);
        addr_r    <= base_r + AW'(MAX_SIDE);
      end else begin
        col_cnt_r <= col_cnt_r + IDX_W'(1);
        addr_r    <= addr_r + AW'(1);
      end
    end

    if (cmd.out_load) begin
      out_tdata_r <= OUT_DATA_W'({pix, res_status});
    end
  end

  // canvas ram, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wdata;
    end
    if (cmd.mem_rd && inrange_r) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign res_status = (kind_r == KIND_DRAW) ? draw_status : STAT_OK;
  assign pix        = ((kind_r == KIND_READ) && inrange_r) ? rd_data_r : 8'd0;

  assign stat.kind      = kind_r;
  assign stat.status    = res_status;
  assign stat.scan_last = col_last && row_last;
  assign out_tdata      = out_tdata_r;

endmodule

/* design/rectangle_canvas_rasterizer.sv */
// Rectangle canvas rasterizer.
// Config port: cfg_we, cfg_index, cfg_wdata write canvas_width (0), canvas_height (1)
// and background_char (2) at any edge with cfg_we high; write only while idle.
// Input stream in_*: tuser carries the item kind (0 clear, 1 draw, 2 read), tdata the
// rectangle and read fields. Output stream out_*: one result per input transaction.
// A clear or a valid draw visits every cell in use, one per cycle, through the single
// canvas ram port, the cells in use being the W*H of the configured canvas size. The
// block takes its next item only after the previous one has loaded its result. A read
// goes from setup through a ram read step to its result; a draw with an error or an
// unused kind goes from setup straight to its result.
// The result sits in an output register; the next item is accepted while it waits.
// When the receiver stalls, a finished item holds in its last step until the result
// register drains, and no new item is taken meanwhile.
// Reset clears the control state and loads the register defaults (256, 256, 32).
// There is no clearing pass: canvas cells are undefined until a clear writes them.
`timescale 1ns / 1ps
`include "rectangle_canvas_rasterizer_defines.svh"

module rectangle_canvas_rasterizer #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // shape_char[7:0], left_x[31:8], top_y[55:32], rect_width[79:56],
  // rect_height[103:80], draw_char[111:104], read_row[119:112], read_col[127:120]
  input  logic [rcr_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], pixel_char[9:2], zeros above
  output logic [rcr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import rcr_pkg::*;

  rcr_cmd_t  cmd;
  rcr_stat_t stat;

  rcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rcr_datapath #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

  `RCR_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `RCR_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_tvalid || out_tready, "result overwritten")
  `RCR_ASSERT_NXT(a_result_shown, cmd.out_load, out_tvalid, "loaded result not shown")

endmodule
